// ===== hdl/mncv_pkg.sv =====
// Package for the MIDI note to CV/gate voice unit.
// Holds request/result types, command and status codes, table sizing and note math.
// No dependencies.
`default_nettype none

package mncv_pkg;

    localparam int MAX_HELD = 16;
    localparam int CNT_W    = $clog2(MAX_HELD + 1);
    localparam int ADR_W    = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;

    localparam logic [6:0] NOTE_C4   = 7'd60;
    localparam logic [6:0] NOTE_EB4  = 7'd63;
    localparam logic [6:0] NOTE_E4   = 7'd64;
    localparam logic [6:0] NOTE_G4   = 7'd67;
    localparam logic [6:0] NOTE_AB4  = 7'd68;
    localparam logic [6:0] NOTE_B4   = 7'd71;
    localparam logic [6:0] NOTE_C5   = 7'd72;
    localparam logic [6:0] NOTE_EB5  = 7'd75;
    localparam logic [7:0] OCTAVE_SHIFT = 8'd12;
    localparam logic [7:0] NOTE_MAX  = 8'd127;

    localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
    localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
    localparam logic [1:0] CMD_TOGGLE   = 2'd2;
    localparam logic [1:0] CMD_CLEAR    = 2'd3;

    localparam logic [2:0] ST_PLAYED   = 3'd0;
    localparam logic [2:0] ST_RELEASED = 3'd1;
    localparam logic [2:0] ST_OFF_KEPT = 3'd2;
    localparam logic [2:0] ST_DUP      = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_NOT_HELD = 3'd5;
    localparam logic [2:0] ST_MODE     = 3'd6;
    localparam logic [2:0] ST_CLEARED  = 3'd7;

    localparam logic [2:0] COL_BLACK  = 3'd0;
    localparam logic [2:0] COL_BLUE   = 3'd1;
    localparam logic [2:0] COL_CYAN   = 3'd2;
    localparam logic [2:0] COL_ORANGE = 3'd3;
    localparam logic [2:0] COL_RED    = 3'd4;

    typedef struct packed {
        logic [1:0] command;
        logic [6:0] note;
        logic [6:0] velocity;
    } t_req;

    typedef struct packed {
        logic [2:0]        status;
        logic              gate_on;
        logic signed [7:0] cv_semitones;
        logic [2:0]        color;
        logic              synth_mode;
        logic [4:0]        notes_held;
    } t_result;

    typedef struct packed {
        logic clear;
        logic idx_clr;
        logic step;
        logic shift;
        logic append;
        logic drop;
    } t_tbl_ctl;

    typedef struct packed {
        logic             hit;
        logic             at_end;
        logic             full;
        logic [CNT_W-1:0] count;
    } t_tbl_stat;

    function automatic logic [2:0] range_color(input logic [6:0] n);
        logic [2:0] c;
        c = COL_BLACK;
        if (n >= NOTE_C4 && n <= NOTE_EB4) begin
            c = COL_BLUE;
        end else if (n >= NOTE_E4 && n <= NOTE_G4) begin
            c = COL_CYAN;
        end else if (n >= NOTE_AB4 && n <= NOTE_B4) begin
            c = COL_ORANGE;
        end else if (n >= NOTE_C5 && n <= NOTE_EB5) begin
            c = COL_RED;
        end
        return c;
    endfunction

    function automatic logic signed [7:0] cv_for(input logic [6:0] n, input logic synth);
        logic [7:0] up;
        logic [7:0] outn;
        up   = {1'b0, n} + OCTAVE_SHIFT;
        outn = {1'b0, n};
        if (synth) begin
            outn = (up > NOTE_MAX) ? NOTE_MAX : up;
        end
        return $signed(outn - {1'b0, NOTE_C4});
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mncv_table.sv =====
// Held-note table: storage, scan index, fill count and the shared note comparator.
// Searches one entry per cycle and compacts one entry per cycle under sequencer control.
// Depends on mncv_pkg.
`default_nettype none

module mncv_table (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  mncv_pkg::t_tbl_ctl   i_ctl,
    input  wire [6:0]            i_note,
    output mncv_pkg::t_tbl_stat  o_stat
);

    logic [6:0]                 r_mem [mncv_pkg::MAX_HELD];
    logic [mncv_pkg::CNT_W-1:0] r_idx;
    logic [mncv_pkg::CNT_W-1:0] n_idx;
    logic [mncv_pkg::CNT_W-1:0] r_count;
    logic [mncv_pkg::CNT_W-1:0] n_count;
    logic [mncv_pkg::CNT_W-1:0] w_prev;
    logic [6:0]                 w_rd;

    assign w_rd   = r_mem[r_idx[mncv_pkg::ADR_W-1:0]];
    assign w_prev = r_idx - {{(mncv_pkg::CNT_W-1){1'b0}}, 1'b1};

    assign o_stat.hit    = (w_rd == i_note);
    assign o_stat.at_end = (r_idx == r_count);
    assign o_stat.full   = (r_count == mncv_pkg::CNT_W'(mncv_pkg::MAX_HELD));
    assign o_stat.count  = r_count;

    always_comb begin
        n_idx   = r_idx;
        n_count = r_count;
        if (i_ctl.idx_clr) begin
            n_idx = '0;
        end else if (i_ctl.step) begin
            n_idx = r_idx + {{(mncv_pkg::CNT_W-1){1'b0}}, 1'b1};
        end
        if (i_ctl.clear) begin
            n_count = '0;
        end else if (i_ctl.append) begin
            n_count = r_count + {{(mncv_pkg::CNT_W-1){1'b0}}, 1'b1};
        end else if (i_ctl.drop) begin
            n_count = r_count - {{(mncv_pkg::CNT_W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_count <= '0;
        end else begin
            r_idx   <= n_idx;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.append) begin
            r_mem[r_count[mncv_pkg::ADR_W-1:0]] <= i_note;
        end else if (i_ctl.shift) begin
            r_mem[w_prev[mncv_pkg::ADR_W-1:0]] <= w_rd;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/midi_note_to_cv_gate_voice_unit.sv =====
// Top level of the MIDI note to CV/gate voice: request sequencer and voice registers.
// Drives the held-note table through search and compaction passes.
// Depends on mncv_pkg and mncv_table.
//
//  channel | ports                  | handshake
//  --------+------------------------+---------------------------------------
//  request | start, busy, i_req     | taken at an edge with start high, busy low
//  result  | o_done, o_result       | o_done high one cycle; no back pressure
//
// Toggle and clear go from the request straight to the result state.
// Note-on scans the N notes held at request, then appends; a repeat ends at its hit.
// Note-off scans to the hit, then compacts the entries above it.
// Busy stays high from request until the result cycle ends; requests wait until then.
// Synchronous active-low reset empties the table and clears gate, CV, color and mode.
`default_nettype none

module midi_note_to_cv_gate_voice_unit (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  mncv_pkg::t_req     i_req,
    output logic               o_done,
    output mncv_pkg::t_result  o_result
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_OUT    = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic              r_is_on,   n_is_on;
    logic [6:0]        r_note,    n_note;
    logic [6:0]        r_last,    n_last;
    logic              r_has_last, n_has_last;
    logic [2:0]        r_color,   n_color;
    logic              r_synth,   n_synth;
    logic              r_gate,    n_gate;
    logic signed [7:0] r_cv,      n_cv;
    logic [2:0]        r_status,  n_status;

    logic                 w_accept;
    logic [1:0]           w_cmd;
    mncv_pkg::t_tbl_ctl   w_ctl;
    mncv_pkg::t_tbl_stat  w_stat;

    mncv_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_note  (r_note),
        .o_stat  (w_stat)
    );

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_cmd    = (i_req.command == mncv_pkg::CMD_NOTE_ON && i_req.velocity == 7'd0)
                      ? mncv_pkg::CMD_NOTE_OFF : i_req.command;

    always_comb begin
        n_state    = r_state;
        n_is_on    = r_is_on;
        n_note     = r_note;
        n_last     = r_last;
        n_has_last = r_has_last;
        n_color    = r_color;
        n_synth    = r_synth;
        n_gate     = r_gate;
        n_cv       = r_cv;
        n_status   = r_status;
        w_ctl      = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (w_cmd)
                        mncv_pkg::CMD_NOTE_ON, mncv_pkg::CMD_NOTE_OFF: begin
                            n_is_on     = (w_cmd == mncv_pkg::CMD_NOTE_ON);
                            n_note      = i_req.note;
                            w_ctl.idx_clr = 1'b1;
                            n_state     = S_SEARCH;
                        end
                        mncv_pkg::CMD_TOGGLE: begin
                            n_synth = !r_synth;
                            if (w_stat.count != '0 && r_has_last) begin
                                n_cv   = mncv_pkg::cv_for(r_last, !r_synth);
                                n_gate = 1'b1;
                            end else begin
                                n_gate = 1'b0;
                            end
                            n_status = mncv_pkg::ST_MODE;
                            n_state  = S_OUT;
                        end
                        default: begin
                            w_ctl.clear = 1'b1;
                            n_last      = '0;
                            n_has_last  = 1'b0;
                            n_color     = mncv_pkg::COL_BLACK;
                            n_gate      = 1'b0;
                            n_cv        = '0;
                            n_status    = mncv_pkg::ST_CLEARED;
                            n_state     = S_OUT;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (w_stat.at_end) begin
                    if (!r_is_on) begin
                        n_status = mncv_pkg::ST_NOT_HELD;
                    end else if (w_stat.full) begin
                        n_status = mncv_pkg::ST_FULL;
                    end else begin
                        w_ctl.append = 1'b1;
                        n_last       = r_note;
                        n_has_last   = 1'b1;
                        n_color      = mncv_pkg::range_color(r_note);
                        n_cv         = mncv_pkg::cv_for(r_note, r_synth);
                        n_gate       = 1'b1;
                        n_status     = mncv_pkg::ST_PLAYED;
                    end
                    n_state = S_OUT;
                end else if (w_stat.hit) begin
                    if (r_is_on) begin
                        n_status = mncv_pkg::ST_DUP;
                        n_state  = S_OUT;
                    end else begin
                        w_ctl.step = 1'b1;
                        n_state    = S_SHIFT;
                    end
                end else begin
                    w_ctl.step = 1'b1;
                end
            end
            S_SHIFT: begin
                if (w_stat.at_end) begin
                    w_ctl.drop = 1'b1;
                    if (w_stat.count == {{(mncv_pkg::CNT_W-1){1'b0}}, 1'b1}) begin
                        n_gate   = 1'b0;
                        n_status = mncv_pkg::ST_RELEASED;
                    end else begin
                        n_status = mncv_pkg::ST_OFF_KEPT;
                    end
                    n_state = S_OUT;
                end else begin
                    w_ctl.shift = 1'b1;
                    w_ctl.step  = 1'b1;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_last     <= '0;
            r_has_last <= 1'b0;
            r_color    <= mncv_pkg::COL_BLACK;
            r_synth    <= 1'b0;
            r_gate     <= 1'b0;
            r_cv       <= '0;
            r_status   <= mncv_pkg::ST_PLAYED;
        end else begin
            r_state    <= n_state;
            r_last     <= n_last;
            r_has_last <= n_has_last;
            r_color    <= n_color;
            r_synth    <= n_synth;
            r_gate     <= n_gate;
            r_cv       <= n_cv;
            r_status   <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_on <= n_is_on;
        r_note  <= n_note;
    end

    assign o_done                = (r_state == S_OUT);
    assign o_result.status       = r_status;
    assign o_result.gate_on      = r_gate;
    assign o_result.cv_semitones = r_cv;
    assign o_result.color        = r_gate ? r_color : mncv_pkg::COL_BLACK;
    assign o_result.synth_mode   = r_synth;
    assign o_result.notes_held   = 5'(w_stat.count);

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("request accepted but sequencer not busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.count <= mncv_pkg::CNT_W'(mncv_pkg::MAX_HELD))
        else $error("held count beyond table depth");

    a_played_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_status == mncv_pkg::ST_PLAYED) |-> (r_gate && w_stat.count != '0))
        else $error("played note without gate or table entry");

    a_released_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_status == mncv_pkg::ST_RELEASED) |-> (!r_gate && w_stat.count == '0))
        else $error("release reported with notes still held");

endmodule

`default_nettype wire

// ===== tb/mncv_voice_checker.sv =====
// Request/result checker for the MIDI note to CV/gate voice unit.
// Keeps its own copy of the voice state and predicts the result of every request.
// Depends on mncv_pkg.
`timescale 1ns / 100ps

module mncv_voice_checker (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wire                i_busy,
    input  mncv_pkg::t_req     i_req,
    input  wire                i_done,
    input  mncv_pkg::t_result  i_result,
    output int                 o_errors,
    output int                 o_pending
);

    logic [6:0]        held_notes [mncv_pkg::MAX_HELD];
    logic [4:0]        held_total;
    logic [6:0]        recent_note;
    logic              recent_valid;
    logic [2:0]        recent_color;
    logic              synth_on;
    logic              gate_state;
    logic signed [7:0] cv_state;

    mncv_pkg::t_result voice_outputs_due [$];

    function automatic logic [2:0] note_band_color(input logic [6:0] n);
        if (n >= mncv_pkg::NOTE_C4 && n <= mncv_pkg::NOTE_EB4) return mncv_pkg::COL_BLUE;
        if (n >= mncv_pkg::NOTE_E4 && n <= mncv_pkg::NOTE_G4) return mncv_pkg::COL_CYAN;
        if (n >= mncv_pkg::NOTE_AB4 && n <= mncv_pkg::NOTE_B4) return mncv_pkg::COL_ORANGE;
        if (n >= mncv_pkg::NOTE_C5 && n <= mncv_pkg::NOTE_EB5) return mncv_pkg::COL_RED;
        return mncv_pkg::COL_BLACK;
    endfunction

    function automatic logic signed [7:0] cv_offset(input logic [6:0] n,
                                                   input logic synth);
        int pitch;
        pitch = int'(n);
        if (synth) begin
            pitch = pitch + int'(mncv_pkg::OCTAVE_SHIFT);
            if (pitch > int'(mncv_pkg::NOTE_MAX)) pitch = int'(mncv_pkg::NOTE_MAX);
        end
        return 8'(pitch - int'(mncv_pkg::NOTE_C4));
    endfunction

    task automatic wipe_voice();
        for (int i = 0; i < mncv_pkg::MAX_HELD; i++) held_notes[i] = '0;
        held_total   = '0;
        recent_note  = '0;
        recent_valid = 1'b0;
        recent_color = mncv_pkg::COL_BLACK;
    endtask

    task automatic next_voice_output(input mncv_pkg::t_req r,
                                     output mncv_pkg::t_result res);
        logic [1:0] cmd;
        logic [2:0] st;
        int         pos;
        cmd = r.command;
        st  = mncv_pkg::ST_PLAYED;
        pos = -1;
        if (cmd == mncv_pkg::CMD_NOTE_ON && r.velocity == 7'd0) cmd = mncv_pkg::CMD_NOTE_OFF;
        for (int i = 0; i < int'(held_total); i++) begin
            if (pos < 0 && held_notes[i] == r.note) pos = i;
        end
        case (cmd)
            mncv_pkg::CMD_NOTE_ON: begin
                if (pos >= 0) begin
                    st = mncv_pkg::ST_DUP;
                end else if (int'(held_total) >= mncv_pkg::MAX_HELD) begin
                    st = mncv_pkg::ST_FULL;
                end else begin
                    held_notes[held_total[3:0]] = r.note;
                    held_total   = held_total + 5'd1;
                    recent_note  = r.note;
                    recent_valid = 1'b1;
                    recent_color = note_band_color(r.note);
                    cv_state     = cv_offset(r.note, synth_on);
                    gate_state   = 1'b1;
                    st           = mncv_pkg::ST_PLAYED;
                end
            end
            mncv_pkg::CMD_NOTE_OFF: begin
                if (pos < 0) begin
                    st = mncv_pkg::ST_NOT_HELD;
                end else begin
                    for (int j = pos + 1; j < int'(held_total); j++) begin
                        held_notes[j-1] = held_notes[j];
                    end
                    held_total = held_total - 5'd1;
                    held_notes[held_total[3:0]] = '0;
                    if (held_total == 5'd0) begin
                        gate_state = 1'b0;
                        st         = mncv_pkg::ST_RELEASED;
                    end else begin
                        st = mncv_pkg::ST_OFF_KEPT;
                    end
                end
            end
            mncv_pkg::CMD_TOGGLE: begin
                synth_on = !synth_on;
                if (held_total > 5'd0 && recent_valid) begin
                    cv_state   = cv_offset(recent_note, synth_on);
                    gate_state = 1'b1;
                end else begin
                    gate_state = 1'b0;
                end
                st = mncv_pkg::ST_MODE;
            end
            default: begin
                wipe_voice();
                gate_state = 1'b0;
                cv_state   = '0;
                st         = mncv_pkg::ST_CLEARED;
            end
        endcase
        res.status       = st;
        res.gate_on      = gate_state;
        res.cv_semitones = cv_state;
        res.color        = gate_state ? recent_color : mncv_pkg::COL_BLACK;
        res.synth_mode   = synth_on;
        res.notes_held   = held_total;
    endtask

    task automatic compare_field(input string field, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (got !== want) begin
            o_errors++;
            $display("%0t checker: %s expected %0d got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        mncv_pkg::t_result want;
        mncv_pkg::t_result pred;
        if (!i_rst_n) begin
            wipe_voice();
            synth_on   = 1'b0;
            gate_state = 1'b0;
            cv_state   = '0;
            voice_outputs_due.delete();
            o_errors   = 0;
        end else begin
            if (i_done) begin
                if (voice_outputs_due.size() == 0) begin
                    o_errors++;
                    $display("%0t checker: result with none expected, got %p",
                             $time, i_result);
                end else begin
                    want = voice_outputs_due.pop_front();
                    compare_field("status", 32'(want.status), 32'(i_result.status));
                    compare_field("gate_on", 32'(want.gate_on), 32'(i_result.gate_on));
                    compare_field("cv_semitones", 32'(want.cv_semitones),
                                  32'(i_result.cv_semitones));
                    compare_field("color", 32'(want.color), 32'(i_result.color));
                    compare_field("synth_mode", 32'(want.synth_mode),
                                  32'(i_result.synth_mode));
                    compare_field("notes_held", 32'(want.notes_held),
                                  32'(i_result.notes_held));
                end
            end
            if (i_start && !i_busy) begin
                next_voice_output(i_req, pred);
                voice_outputs_due.push_back(pred);
            end
        end
        o_pending = voice_outputs_due.size();
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the MIDI note to CV/gate voice unit: clock, reset, requests, verdict.
// Directed requests first, then random note sequences from shifting note pools.
// Depends on mncv_pkg, midi_note_to_cv_gate_voice_unit and mncv_voice_checker.
`timescale 1ns / 100ps

module tb;

    localparam int RANDOM_REQUESTS = 1450;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 40;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    mncv_pkg::t_req    req_bus = '0;
    wire               busy;
    wire               o_done;
    mncv_pkg::t_result o_result;

    int      fail_count;
    int      due_count;
    int      quiet_cycles = 0;
    bit      gaps_enabled = 1'b1;

    always #1 i_clk = ~i_clk;

    midi_note_to_cv_gate_voice_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (req_bus),
        .o_done   (o_done),
        .o_result (o_result)
    );

    mncv_voice_checker u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_req     (req_bus),
        .i_done    (o_done),
        .i_result  (o_result),
        .o_errors  (fail_count),
        .o_pending (due_count)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("tb: done, errors");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_request(input logic [1:0] cmd, input logic [6:0] n,
                                input logic [6:0] vel);
        int gap;
        gap = gaps_enabled ? int'($urandom_range(0, 4)) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start   <= 1'b1;
        req_bus <= '{command: cmd, note: n, velocity: vel};
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    initial begin
        int         pick;
        int         pool_base;
        int         pool_span;
        logic [6:0] n;
        logic [6:0] vel;
        logic [1:0] cmd;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_request(mncv_pkg::CMD_NOTE_OFF, 7'd0, 7'd0);
        send_request(mncv_pkg::CMD_TOGGLE, 7'd127, 7'd127);
        send_request(mncv_pkg::CMD_NOTE_ON, 7'd127, 7'd127);
        send_request(mncv_pkg::CMD_NOTE_ON, 7'd116, 7'd1);
        send_request(mncv_pkg::CMD_NOTE_ON, 7'd115, 7'd64);
        send_request(mncv_pkg::CMD_TOGGLE, 7'd0, 7'd0);
        send_request(mncv_pkg::CMD_NOTE_ON, mncv_pkg::NOTE_C4, 7'd1);
        send_request(mncv_pkg::CMD_NOTE_ON, mncv_pkg::NOTE_EB4, 7'd2);
        send_request(mncv_pkg::CMD_NOTE_ON, mncv_pkg::NOTE_E4, 7'd3);
        send_request(mncv_pkg::CMD_NOTE_ON, mncv_pkg::NOTE_G4, 7'd4);
        send_request(mncv_pkg::CMD_NOTE_ON, mncv_pkg::NOTE_AB4, 7'd5);
        send_request(mncv_pkg::CMD_NOTE_ON, mncv_pkg::NOTE_B4, 7'd6);
        send_request(mncv_pkg::CMD_NOTE_ON, mncv_pkg::NOTE_C5, 7'd7);
        send_request(mncv_pkg::CMD_NOTE_ON, mncv_pkg::NOTE_EB5, 7'd8);
        send_request(mncv_pkg::CMD_NOTE_ON, 7'd76, 7'd9);
        send_request(mncv_pkg::CMD_NOTE_ON, 7'd59, 7'd10);
        send_request(mncv_pkg::CMD_NOTE_ON, mncv_pkg::NOTE_C4, 7'd127);
        send_request(mncv_pkg::CMD_NOTE_ON, 7'd0, 7'd85);
        send_request(mncv_pkg::CMD_NOTE_ON, 7'd1, 7'd42);
        send_request(mncv_pkg::CMD_NOTE_ON, 7'd2, 7'd127);
        send_request(mncv_pkg::CMD_NOTE_ON, 7'd3, 7'd127);
        send_request(mncv_pkg::CMD_NOTE_OFF, 7'd127, 7'd0);
        send_request(mncv_pkg::CMD_NOTE_ON, 7'd2, 7'd0);
        send_request(mncv_pkg::CMD_CLEAR, 7'd85, 7'd42);
        send_request(mncv_pkg::CMD_NOTE_ON, 7'd62, 7'd100);
        send_request(mncv_pkg::CMD_NOTE_OFF, 7'd62, 7'd127);

        pool_base = 0;
        pool_span = 0;
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i % 64 == 0) begin
                gaps_enabled = ($urandom_range(0, 3) != 0);
                pool_base    = ($urandom_range(0, 1) == 0) ? $urandom_range(52, 72)
                                                           : $urandom_range(0, 104);
                pool_span    = $urandom_range(4, 23);
            end
            if ($urandom_range(0, 6) == 0) begin
                n = 7'($urandom);
            end else begin
                n = 7'(pool_base + int'($urandom_range(0, pool_span)));
            end
            vel  = 7'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 48) begin
                cmd = mncv_pkg::CMD_NOTE_ON;
                vel = 7'($urandom_range(1, 127));
            end else if (pick < 78) begin
                cmd = mncv_pkg::CMD_NOTE_OFF;
            end else if (pick < 86) begin
                cmd = mncv_pkg::CMD_NOTE_ON;
                vel = '0;
            end else if (pick < 92) begin
                cmd = mncv_pkg::CMD_TOGGLE;
            end else if (pick < 94) begin
                cmd = mncv_pkg::CMD_CLEAR;
            end else begin
                cmd = 2'($urandom);
                n   = 7'($urandom);
            end
            send_request(cmd, n, vel);
        end

        start <= 1'b0;
        wait (due_count == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && due_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mncv_pkg.sv
hdl/mncv_table.sv
hdl/midi_note_to_cv_gate_voice_unit.sv
tb/mncv_voice_checker.sv
tb/tb.sv
